[design/crr_pkg.sv]
// Shared constants and controller/datapath interface types for the record resampler.
package crr_pkg;

    // Default fixed-point layout and run limits
    localparam int FRAC_BITS_DEF   = 16;
    localparam int MAX_SAMPLES_DEF = 64;

    // Fixed field widths of the streams
    localparam int ELAPSED_W = 22;
    localparam int KIND_W    = 2;
    localparam int SAMPLE_W  = 8;
    localparam int IN_DATA_W = 24;

    // Item kinds
    localparam logic [KIND_W-1:0] KIND_ADVANCE = 2'd0;
    localparam logic [KIND_W-1:0] KIND_START   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_STOP    = 2'd2;

    // Commands from the controller
    typedef struct packed {
        logic load;    // latch the input word
        logic check;   // apply elapsed time to the open interval
        logic prep;    // feed a new filter input
        logic emit;    // produce one sample and decay the filter
        logic run2;    // current run is the whole-interval run
        logic finish;  // apply the item kind
    } t_cmd;

    // Status back to the controller
    typedef struct packed {
        logic active;   // recording, and tape rolling or motor control off
        logic closes;   // elapsed time closes the open interval
        logic more;     // whole intervals follow the first one
        logic stall;    // output register busy
        logic run_end;  // current sample ends its run
    } t_status;

endpackage

[design/crr_ctrl.sv]
// Sequencing state machine of the record resampler.
module crr_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    input  crr_pkg::t_status i_status,
    output crr_pkg::t_cmd    o_cmd
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_CHECK  = 3'd1;
    localparam logic [2:0] S_PREP1  = 3'd2;
    localparam logic [2:0] S_EMIT1  = 3'd3;
    localparam logic [2:0] S_PREP2  = 3'd4;
    localparam logic [2:0] S_EMIT2  = 3'd5;
    localparam logic [2:0] S_FINISH = 3'd6;

    logic [2:0] r_state;
    logic [2:0] n_state;

    assign o_s_axis_tready = (r_state == S_IDLE);

    // Decode commands and next state
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_s_axis_tvalid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_CHECK;
                end
            end
            S_CHECK: begin
                o_cmd.check = 1'b1;
                n_state = (i_status.active && i_status.closes) ? S_PREP1 : S_FINISH;
            end
            S_PREP1: begin
                o_cmd.prep = 1'b1;
                n_state    = S_EMIT1;
            end
            S_EMIT1: begin
                o_cmd.emit = 1'b1;
                if (!i_status.stall) begin
                    n_state = i_status.more ? S_PREP2 : S_FINISH;
                end
            end
            S_PREP2: begin
                o_cmd.prep = 1'b1;
                o_cmd.run2 = 1'b1;
                n_state    = S_EMIT2;
            end
            S_EMIT2: begin
                o_cmd.emit = 1'b1;
                o_cmd.run2 = 1'b1;
                if (!i_status.stall && i_status.run_end) begin
                    n_state = S_FINISH;
                end
            end
            S_FINISH: begin
                o_cmd.finish = 1'b1;
                n_state      = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Advance state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

[design/crr_dp.sv]
// Datapath of the record resampler: interval fill, DC-blocking filter and output register.
module crr_dp #(
    parameter int FRAC_BITS   = crr_pkg::FRAC_BITS_DEF,
    parameter int MAX_SAMPLES = crr_pkg::MAX_SAMPLES_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_valid,
    input  logic                          i_cfg_data,
    input  logic [crr_pkg::IN_DATA_W-1:0] i_s_axis_tdata,
    input  logic [crr_pkg::KIND_W-1:0]    i_s_axis_tuser,
    output logic                          o_m_axis_tvalid,
    input  logic                          i_m_axis_tready,
    output logic [crr_pkg::SAMPLE_W-1:0]  o_m_axis_tdata,
    output logic                          o_m_axis_tlast,
    input  crr_pkg::t_cmd                 i_cmd,
    output crr_pkg::t_status              o_status
);

    localparam int EW   = crr_pkg::ELAPSED_W;
    localparam int ETW  = (FRAC_BITS + 1 > EW) ? FRAC_BITS + 1 : EW;
    localparam int CW   = ETW - FRAC_BITS;
    localparam int SW   = FRAC_BITS + 8;   // interval sums and filter inputs
    localparam int YW   = FRAC_BITS + 10;  // filter state
    localparam int EMW  = $clog2(MAX_SAMPLES + 1);

    localparam logic [FRAC_BITS:0]     ONE   = {1'b1, {FRAC_BITS{1'b0}}};
    localparam logic signed [YW:0]     LIM_P = {2'b00, {(YW-1){1'b1}}};
    localparam logic signed [YW:0]     LIM_N = -LIM_P;
    localparam logic signed [YW-1:0]   RND_Q = {{(YW-FRAC_BITS){1'b0}}, {FRAC_BITS{1'b1}}};
    localparam logic signed [YW+7:0]   RND_D = (YW+8)'(255);
    localparam logic [EMW-1:0]         CAP   = EMW'(MAX_SAMPLES);
    localparam logic [EMW-1:0]         CAP_M1 = EMW'(MAX_SAMPLES - 1);

    // Level amplitude (+/-60) times a time span
    function automatic logic signed [SW-1:0] f_amp(input logic lvl,
                                                   input logic [FRAC_BITS:0] v);
        logic [FRAC_BITS+6:0] m;
        m = {v, 6'b0} - {2'b00, v, 2'b0};
        return lvl ? $signed({1'b0, m}) : -$signed({1'b0, m});
    endfunction

    // Configuration and item registers
    logic                        r_mc;
    logic [crr_pkg::KIND_W-1:0]  r_kind;
    logic [EW-1:0]               r_e;
    logic                        r_lvl_in;
    logic                        r_mot_in;

    // Block state
    logic                        r_rec;
    logic                        r_lvl;
    logic                        r_mot;
    logic [FRAC_BITS-1:0]        r_ff;
    logic signed [SW-1:0]        r_fs;
    logic signed [SW-1:0]        r_xp;
    logic signed [YW-1:0]        r_y;

    // Run registers
    logic signed [SW-1:0]        r_x;
    logic [CW-1:0]               r_cnt;
    logic [CW-1:0]               r_n;
    logic [EMW-1:0]              r_emit_cnt;

    // Output register
    logic                        r_ovalid;
    logic [crr_pkg::SAMPLE_W-1:0] r_odata;
    logic                        r_olast;

    // Interval arithmetic
    logic [FRAC_BITS:0]          rest;
    logic [ETW-1:0]              e_x;
    logic [ETW-1:0]              rest_x;
    logic [ETW-1:0]              e2;
    logic                        closes;
    logic                        active;
    logic [FRAC_BITS-1:0]        e_lo;

    assign rest   = ONE - {1'b0, r_ff};
    assign e_x    = ETW'(r_e);
    assign rest_x = ETW'(rest);
    assign closes = (rest_x <= e_x);
    assign e2     = e_x - rest_x;
    assign e_lo   = e_x[FRAC_BITS-1:0];
    assign active = r_rec && (r_mot || !r_mc);

    // Filter input update with saturation
    logic signed [SW-1:0]  x_sel;
    logic signed [YW:0]    sx;
    logic signed [YW-1:0]  n_y_sat;

    assign x_sel = i_cmd.run2 ? f_amp(r_lvl, ONE) : r_x;
    assign sx    = (YW+1)'(r_y) + (YW+1)'(x_sel) - (YW+1)'(r_xp);

    always_comb begin
        if (sx > LIM_P) begin
            n_y_sat = LIM_P[YW-1:0];
        end else if (sx < LIM_N) begin
            n_y_sat = LIM_N[YW-1:0];
        end else begin
            n_y_sat = sx[YW-1:0];
        end
    end

    // Sample value: truncate toward zero, offset, clamp
    logic signed [YW-1:0]               yr;
    logic signed [YW-FRAC_BITS:0]       sv;
    logic [crr_pkg::SAMPLE_W-1:0]       n_sample;

    assign yr = r_y[YW-1] ? r_y + RND_Q : r_y;
    assign sv = $signed({yr[YW-1], yr[YW-1:FRAC_BITS]}) + (YW-FRAC_BITS+1)'(128);

    always_comb begin
        if (sv[YW-FRAC_BITS]) begin
            n_sample = '0;
        end else if (sv > (YW-FRAC_BITS+1)'(255)) begin
            n_sample = '1;
        end else begin
            n_sample = sv[crr_pkg::SAMPLE_W-1:0];
        end
    end

    // Decay by 252/256, toward zero
    logic signed [YW+7:0] dp;
    logic signed [YW+7:0] dr;
    logic signed [YW-1:0] n_y_dec;

    assign dp      = $signed({r_y, 8'b0}) - $signed({{6{r_y[YW-1]}}, r_y, 2'b0});
    assign dr      = dp[YW+7] ? dp + RND_D : dp;
    assign n_y_dec = dr[YW+7:8];

    // Emission control
    logic cap;
    logic stall;
    logic fire;
    logic last;

    assign cap   = (r_emit_cnt == CAP);
    assign stall = !cap && r_ovalid && !i_m_axis_tready;
    assign fire  = i_cmd.emit && !stall;
    assign last  = (i_cmd.run2 ? (r_n == CW'(1)) : (r_cnt == '0)) || (r_emit_cnt == CAP_M1);

    assign o_status.active  = active;
    assign o_status.closes  = closes;
    assign o_status.more    = (r_cnt != '0);
    assign o_status.stall   = stall;
    assign o_status.run_end = (r_n == CW'(1));

    // Configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mc <= 1'b1;
        end else if (i_cfg_valid) begin
            r_mc <= i_cfg_data;
        end
    end

    // Latch the input word
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_kind   <= i_s_axis_tuser;
            r_e      <= i_s_axis_tdata[EW-1:0];
            r_lvl_in <= i_s_axis_tdata[EW];
            r_mot_in <= i_s_axis_tdata[EW+1];
        end
    end

    // Fill, filter and kind handling
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rec      <= 1'b0;
            r_lvl      <= 1'b0;
            r_mot      <= 1'b0;
            r_ff       <= '0;
            r_fs       <= '0;
            r_xp       <= '0;
            r_y        <= '0;
            r_x        <= '0;
            r_cnt      <= '0;
            r_n        <= '0;
            r_emit_cnt <= '0;
        end else begin
            if (i_cmd.load) begin
                r_emit_cnt <= '0;
            end
            if (i_cmd.check && active) begin
                if (closes) begin
                    r_x   <= r_fs + f_amp(r_lvl, rest);
                    r_cnt <= e2[ETW-1:FRAC_BITS];
                    r_ff  <= e2[FRAC_BITS-1:0];
                    r_fs  <= f_amp(r_lvl, {1'b0, e2[FRAC_BITS-1:0]});
                end else begin
                    r_ff  <= r_ff + e_lo;
                    r_fs  <= r_fs + f_amp(r_lvl, {1'b0, e_lo});
                end
            end
            if (i_cmd.prep) begin
                r_y  <= n_y_sat;
                r_xp <= x_sel;
                r_n  <= i_cmd.run2 ? r_cnt : CW'(1);
            end
            if (fire) begin
                r_y <= n_y_dec;
                r_n <= r_n - CW'(1);
                if (!cap) begin
                    r_emit_cnt <= r_emit_cnt + EMW'(1);
                end
            end
            if (i_cmd.finish) begin
                unique case (r_kind)
                    crr_pkg::KIND_ADVANCE: begin
                        r_lvl <= r_lvl_in;
                        r_mot <= r_mot_in;
                    end
                    crr_pkg::KIND_START: begin
                        r_rec <= 1'b1;
                        r_ff  <= '0;
                        r_fs  <= '0;
                        r_xp  <= f_amp(r_lvl, ONE);
                        r_y   <= '0;
                    end
                    crr_pkg::KIND_STOP: begin
                        r_rec <= 1'b0;
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    // Output register: load a word when free, drop it when taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (fire && !cap) begin
            r_ovalid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire && !cap) begin
            r_odata <= n_sample;
            r_olast <= last;
        end
    end

    assign o_m_axis_tvalid = r_ovalid;
    assign o_m_axis_tdata  = r_odata;
    assign o_m_axis_tlast  = r_olast;

endmodule

[design/cassette_record_resampler.sv]
// Cassette record resampler: 1-bit tape level in, 8-bit unsigned samples out.
//
// Input stream (s_axis): one word per event. tuser carries the kind (advance,
// start recording, stop recording); tdata carries elapsed time in
// 1/2^FRAC_BITS sample units, the new level and the new motor state.
// Output stream (m_axis): one word per sample, tdata = sample (128 is zero),
// tlast marks the final sample caused by an input word.
// Config channel: one bit, motor_control; always ready, write it only while
// the block is idle.
// Timing: an input word is taken only in the idle state. A word that closes
// no interval goes from check to finish; one that closes intervals adds a
// prep and an emit step for the first interval and, when whole intervals follow,
// a second prep step and an emit step per remaining sample. The per-sample filter
// step is the limiting loop. The first sample enters the output register in the first emit step.
// Receiver stall: the single output register holds its word and the sample
// sequencer waits until it is taken; no samples are lost.
// Reset: synchronous, active low; recording stops, the filter and interval
// state clear and motor_control returns to 1.
module cassette_record_resampler #(
    parameter int FRAC_BITS   = crr_pkg::FRAC_BITS_DEF,
    parameter int MAX_SAMPLES = crr_pkg::MAX_SAMPLES_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // Configuration: motor_control
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic                          i_cfg_data,
    // Input stream
    input  logic                          i_s_axis_tvalid,
    output logic                          o_s_axis_tready,
    input  logic [crr_pkg::IN_DATA_W-1:0] i_s_axis_tdata,  // elapsed[21:0], level, motor_on
    input  logic [crr_pkg::KIND_W-1:0]    i_s_axis_tuser,  // kind
    // Output stream
    output logic                          o_m_axis_tvalid,
    input  logic                          i_m_axis_tready,
    output logic [crr_pkg::SAMPLE_W-1:0]  o_m_axis_tdata,  // sample
    output logic                          o_m_axis_tlast
);

    crr_pkg::t_cmd    cmd;
    crr_pkg::t_status status;

    assign o_cfg_ready = 1'b1;

    crr_ctrl u_ctrl (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_status        (status),
        .o_cmd           (cmd)
    );

    crr_dp #(
        .FRAC_BITS   (FRAC_BITS),
        .MAX_SAMPLES (MAX_SAMPLES)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_valid     (i_cfg_valid),
        .i_cfg_data      (i_cfg_data),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tlast  (o_m_axis_tlast),
        .i_cmd           (cmd),
        .o_status        (status)
    );

endmodule
